// ===== sv/btn_mode_pkg.sv =====
// ----------------------------------------------------------------------------
// btn_mode_pkg
// shared constants for the button press mode selector and its checker
// ----------------------------------------------------------------------------
package btn_mode_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BOUNCE_MS  = 2'd0;
   localparam logic [1:0] CSR_LONG_MS    = 2'd1;
   localparam logic [1:0] CSR_MODE_COUNT = 2'd2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int BOUNCE_W = 10;
   localparam int LONG_W   = 16;
   localparam int COUNT_W  = 4;
   localparam int MODE_W   = 3;

   // register values after reset
   localparam logic [BOUNCE_W-1:0] BOUNCE_RESET = 10'd100;
   localparam logic [LONG_W-1:0]   LONG_RESET   = 16'd1000;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd5;

   // highest mode index the display field can carry
   localparam logic [COUNT_W-1:0]  MODE_LAST    = 4'd7;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   // response field positions in rsp_tdata
   localparam int RSP_MODE_LSB    = 0;
   localparam int RSP_CHANGED_BIT = 3;
   localparam int RSP_TOGGLED_BIT = 4;
   localparam int RSP_FIRST_BIT   = 5;
   localparam int RSP_SECOND_BIT  = 6;

endpackage

// ===== sv/button_short_long_press_mode_select_top.sv =====
// ----------------------------------------------------------------------------
// button_short_long_press_mode_select_top
// debounced short/long press detector driving display mode and device select
// ----------------------------------------------------------------------------
// a request accepted at one edge has its response registered and shown in the next cycle
// throughput: one request per cycle, limited only by rsp_tready
// the single output register sets the rate: req_tready is high while it is
// empty or being drained in the same cycle
// reset (synchronous, active high) restores the register defaults, mode 0 and
// the first source selected, with no response pending
// ----------------------------------------------------------------------------
module button_short_long_press_mode_select_top #(
   parameter int TIME_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [btn_mode_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] button_level
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [2:0] display_mode, [3] mode_changed, [4] device_toggled,
   // [5] first_select, [6] second_select, [7] zero
   output logic [btn_mode_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [btn_mode_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [btn_mode_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // compare width wide enough for both the counter and the long press time
   localparam int CMP_W = (TIME_BITS > btn_mode_pkg::LONG_W) ?
                          TIME_BITS : btn_mode_pkg::LONG_W;

   // configuration registers
   logic [btn_mode_pkg::BOUNCE_W-1:0] bounce_ms_ff;
   logic [btn_mode_pkg::LONG_W-1:0]   long_ms_ff;
   logic [btn_mode_pkg::COUNT_W-1:0]  mode_count_ff;

   // press tracking state
   logic                              pressed_ff, pressed_in;
   logic                              armed_ff, armed_in;
   logic                              long_seen_ff, long_seen_in;
   logic [TIME_BITS-1:0]              elapsed_ff, elapsed_in;
   logic [btn_mode_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic                              device_ff, device_in;

   // output register
   logic                              rsp_valid_ff;
   logic                              changed_ff, changed_in;
   logic                              toggled_ff, toggled_in;

   logic                              accept;
   logic                              level;

   // the output register takes a new response when empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];

   // one tick of the press tracker
   always_comb begin
      logic [btn_mode_pkg::COUNT_W-1:0] mode_plus;
      logic [CMP_W-1:0]                 elapsed_wide;

      pressed_in   = pressed_ff;
      armed_in     = armed_ff;
      long_seen_in = long_seen_ff;
      elapsed_in   = elapsed_ff;
      mode_in      = mode_ff;
      device_in    = device_ff;
      changed_in   = 1'b0;
      toggled_in   = 1'b0;

      // running press counter, stops at all ones
      if (pressed_ff && !(&elapsed_ff)) begin
         elapsed_in = elapsed_ff + TIME_BITS'(1);
      end

      // press start restarts the counter, release drops the press
      if (level && !pressed_ff) begin
         elapsed_in = '0;
         pressed_in = 1'b1;
      end else if (!level) begin
         pressed_in = 1'b0;
      end

      // release of an armed press: short press unless a long press fired
      mode_plus = {1'b0, mode_ff} + btn_mode_pkg::COUNT_W'(1);
      if (!level && armed_ff) begin
         if (!long_seen_ff) begin
            if (mode_plus >= mode_count_ff || mode_plus > btn_mode_pkg::MODE_LAST) begin
               mode_in = '0;
            end else begin
               mode_in = mode_plus[btn_mode_pkg::MODE_W-1:0];
            end
            changed_in = 1'b1;
         end
         long_seen_in = 1'b0;
         armed_in     = 1'b0;
      end

      // debounced hold; a held press implies the level is high here, so the
      // held time is the elapsed count itself
      elapsed_wide = CMP_W'(elapsed_in);
      if (pressed_in && elapsed_wide >= CMP_W'(bounce_ms_ff)) begin
         armed_in = 1'b1;
         if (elapsed_wide >= CMP_W'(long_ms_ff)) begin
            // long press: toggle the device and restart the press
            long_seen_in = 1'b1;
            pressed_in   = 1'b0;
            device_in    = !device_ff;
            toggled_in   = 1'b1;
         end
      end
   end

   // configuration writes, indexes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bounce_ms_ff  <= btn_mode_pkg::BOUNCE_RESET;
         long_ms_ff    <= btn_mode_pkg::LONG_RESET;
         mode_count_ff <= btn_mode_pkg::COUNT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            btn_mode_pkg::CSR_BOUNCE_MS: begin
               bounce_ms_ff <= csr_wdata[btn_mode_pkg::BOUNCE_W-1:0];
            end
            btn_mode_pkg::CSR_LONG_MS: begin
               long_ms_ff <= csr_wdata[btn_mode_pkg::LONG_W-1:0];
            end
            btn_mode_pkg::CSR_MODE_COUNT: begin
               mode_count_ff <= csr_wdata[btn_mode_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // tracker state advances only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         armed_ff     <= 1'b0;
         long_seen_ff <= 1'b0;
         elapsed_ff   <= '0;
         mode_ff      <= '0;
         device_ff    <= 1'b0;
      end else if (accept) begin
         pressed_ff   <= pressed_in;
         armed_ff     <= armed_in;
         long_seen_ff <= long_seen_in;
         elapsed_ff   <= elapsed_in;
         mode_ff      <= mode_in;
         device_ff    <= device_in;
      end
   end

   // output register: the pulses are held with the response they belong to
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         changed_ff <= changed_in;
         toggled_ff <= toggled_in;
      end
   end

   // mode and selects come straight from state, which is stable while stalled
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, ~device_ff ? 1'b0 : 1'b1, ~device_ff, toggled_ff,
                        changed_ff, mode_ff};

endmodule

// ===== sv/btn_mode_checker.sv =====
// ----------------------------------------------------------------------------
// btn_mode_checker
// port-level checks for the button press mode selector
// ----------------------------------------------------------------------------
module btn_mode_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [btn_mode_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // an accepted request always has its response up on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("response missing after accepted request");

   // a short press needs a release, a long press a held level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[btn_mode_pkg::RSP_CHANGED_BIT] &&
                       rsp_tdata[btn_mode_pkg::RSP_TOGGLED_BIT]))
      else $error("mode change and device toggle in one response");

   // the two mux selects are always complementary
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[btn_mode_pkg::RSP_FIRST_BIT] !=
                     rsp_tdata[btn_mode_pkg::RSP_SECOND_BIT])
      else $error("mux selects not complementary");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind button_short_long_press_mode_select_top btn_mode_checker u_btn_mode_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
